[design/sem_pkg.sv]
// shared types and constants for the sobel edge magnitude block
`default_nettype none
package sem_pkg;
  localparam int unsigned PixW = 8;
  localparam int unsigned GradW = 11;
  localparam int unsigned EnergyW = 21;
  localparam int unsigned CfgWidthW = 11;
  localparam int unsigned CfgHeightW = 16;
  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SQRT,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

[design/sem_isqrt.sv]
// iterative floor square root, one result bit per cycle
`default_nettype none
module sem_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sem_pkg::EnergyW-1:0]   value_i,
  output logic                               done_o,
  output logic [sem_pkg::PixW-1:0]           root_o
);
  import sem_pkg::*;

  // result fits in 11 bits; 11 steps of one bit each
  localparam int unsigned RootW = 11;

  logic [EnergyW-1:0] rem_q, rem_d;
  logic [EnergyW-1:0] bit_q, bit_d;
  logic [EnergyW-1:0] root_q, root_d;
  logic               busy_q, busy_d;
  logic [EnergyW-1:0] trial;

  always_comb begin
    rem_d  = rem_q;
    bit_d  = bit_q;
    root_d = root_q;
    busy_d = busy_q;
    trial  = root_q + bit_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      bit_d  = EnergyW'(1) << (EnergyW - 1);
      root_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  assign root_o = (root_q[RootW-1:PixW] != '0) ? {PixW{1'b1}} : root_q[PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    root_q <= root_d;
  end
endmodule
`default_nettype wire

[design/sobel_edge_magnitude_3x3.sv]
// 3x3 sobel edge detector: top level with line memories and window
//
// usage: pixels enter on the s_axis channel in raster order, one per beat;
// tuser marks the first pixel of a frame and clears the position counters.
// for each interior pixel one beat leaves on m_axis carrying the magnitude
// and the signed gradients; tlast marks the last interior pixel of a frame.
// border pixels produce no output beat.
// the user sets image width and height over the apb port only while the block
// is idle; the block does not enforce it. reset values are 640 by 480.
// flow: the accept registers the pixel and reads the line memories, ST_READ
// forms the gradients and registers the energy, ST_SQRT starts the square
// root, and ST_OUT waits for its done, which loads the output register.
// a new pixel is taken only back in the idle state: after ST_READ for border
// pixels, and after the iterative square root unit for interior pixels.
// s_axis_tready is high only in the idle state. a stalled receiver holds
// the result in the output register while pixels keep coming; the next
// interior pixel waits before its square root until that beat is taken.
// reset clears counters and the window; line memories keep contents.
`default_nettype none
module sobel_edge_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // pixel
  input  wire logic        s_axis_tuser,   // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // magnitude, grad_x, grad_y, zero fill
  output logic             m_axis_tlast,   // frame_end
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sem_pkg::*;

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1);

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [ColW-1:0]       col_q, col_d;
  logic [15:0]           row_q, row_d;
  logic [PixW-1:0]       win_q [6];
  logic [PixW-1:0]       pix_q;
  logic [ColW-1:0]       cur_col_q;
  logic [15:0]           cur_row_q;
  state_e                state_q, state_d;

  logic [PixW-1:0] mem_above [MAX_WIDTH];
  logic [PixW-1:0] mem_two [MAX_WIDTH];
  logic [PixW-1:0] rd_above_q, rd_two_q;

  logic [GradW-1:0] gx_q, gy_q;
  logic             last_q;
  logic [PixW-1:0]  mag_q;
  logic [GradW-1:0] out_gx_q, out_gy_q;
  logic             out_last_q;
  logic             out_valid_q;

  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(640);
      height_q <= CfgHeightW'(480);
    end else if (cfg_wr) begin
      case (paddr[2])
        RegWidth:  width_q  <= pwdata[CfgWidthW-1:0];
        RegHeight: height_q <= pwdata[CfgHeightW-1:0];
        default:   ;
      endcase
    end
  end

  // effective width and height
  logic [CfgWidthW+1:0] w_eff;
  logic [16:0]          h_eff;
  always_comb begin
    if (width_q < CfgWidthW'(3)) w_eff = (CfgWidthW+2)'(3);
    else if (32'(width_q) > MAX_WIDTH) w_eff = (CfgWidthW+2)'(MAX_WIDTH);
    else w_eff = (CfgWidthW+2)'(width_q);
    h_eff = (height_q < CfgHeightW'(3)) ? 17'd3 : 17'(height_q);
  end

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [ColW-1:0] acc_col;
  logic [15:0]     acc_row;
  assign acc_col = s_axis_tuser ? '0 : col_q;
  assign acc_row = s_axis_tuser ? '0 : row_q;

  logic cur_in_range;
  assign cur_in_range = 32'(cur_col_q) < MAX_WIDTH;

  // memory read at accept, write back in ST_READ
  always_ff @(posedge clk_i) begin
    if (in_acc && 32'(acc_col) < MAX_WIDTH) begin
      rd_above_q <= mem_above[acc_col[AddrW-1:0]];
      rd_two_q   <= mem_two[acc_col[AddrW-1:0]];
    end else if (in_acc) begin
      rd_above_q <= '0;
      rd_two_q   <= '0;
    end
    if (state_q == ST_READ && cur_in_range) begin
      mem_two[cur_col_q[AddrW-1:0]]   <= rd_above_q;
      mem_above[cur_col_q[AddrW-1:0]] <= pix_q;
    end
  end

  logic last_col, last_row, interior;
  assign last_col = (17'(cur_col_q) + 17'd1) >= 17'(w_eff);
  assign last_row = (17'(cur_row_q) + 17'd1) >= h_eff;
  assign interior = (cur_row_q >= 16'd2) && (cur_col_q >= ColW'(2));

  // gradients
  logic signed [GradW-1:0] top, mid, bot, lt, lm, lb, mt, mb, gx, gy;
  assign top = GradW'(rd_two_q);
  assign mid = GradW'(rd_above_q);
  assign bot = GradW'(pix_q);
  assign lt  = GradW'(win_q[0]);
  assign lm  = GradW'(win_q[1]);
  assign lb  = GradW'(win_q[2]);
  assign mt  = GradW'(win_q[3]);
  assign mb  = GradW'(win_q[5]);
  assign gx  = (top + (mid <<< 1) + bot) - (lt + (lm <<< 1) + lb);
  assign gy  = (lb + (mb <<< 1) + bot) - (lt + (mt <<< 1) + top);

  logic [EnergyW-1:0] energy_q;
  logic               sq_start, sq_done;
  logic [PixW-1:0]    sq_root;
  logic signed [2*GradW-1:0] gx2, gy2;
  assign gx2 = gx * gx;
  assign gy2 = gy * gy;

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    sq_start = 1'b0;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: begin
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : cur_row_q + 16'd1;
        end else begin
          col_d = cur_col_q + ColW'(1);
        end
        if (interior) state_d = ST_SQRT;
        else state_d = ST_IDLE;
      end
      ST_SQRT: begin
        // wait until the output register is free or being taken
        if (!out_valid_q || m_axis_tready) begin
          sq_start = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: if (sq_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  sem_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .value_i(energy_q),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (state_q == ST_READ) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= rd_two_q;
        win_q[4] <= rd_above_q;
        win_q[5] <= pix_q;
      end
      if (state_q == ST_OUT && sq_done) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q     <= s_axis_tdata;
      cur_col_q <= acc_col;
      cur_row_q <= acc_row;
    end
    if (state_q == ST_READ) begin
      gx_q     <= gx;
      gy_q     <= gy;
      last_q   <= last_col && last_row;
      energy_q <= EnergyW'(gx2) + EnergyW'(gy2);
    end
    if (state_q == ST_OUT && sq_done) begin
      mag_q      <= sq_root;
      out_gx_q   <= gx_q;
      out_gy_q   <= gy_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_gy_q, out_gx_q, mag_q};
  assign m_axis_tlast  = out_last_q;
endmodule
`default_nettype wire

[tb/sv/sem_checker.sv]
// checker: watches the pixel and result streams, predicts sobel results and compares
`timescale 1ns / 1ps
module sem_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pix_valid,
  input  logic        pix_ready,
  input  logic [7:0]  pix_data,
  input  logic        pix_first,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [31:0] res_data,
  input  logic        res_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0]  mag;
    logic [10:0] gx;
    logic [10:0] gy;
    logic        last;
  } edge_res_t;

  edge_res_t           edge_q[$];
  logic [10:0]         width_reg;
  logic [15:0]         height_reg;
  logic [7:0]          row1_mem[MAX_WIDTH];
  logic [7:0]          row2_mem[MAX_WIDTH];
  logic [7:0]          win[6];
  int unsigned         col_pos, row_pos;

  assign pending_count = edge_q.size();

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  task automatic predict_pixel(input logic [7:0] px, input logic first);
    int unsigned w, h, c, r, mag;
    int top, mid, bot, gx, gy;
    logic lc, lr;
    edge_res_t e;
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    if (first) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    bot = px;
    top = (c < MAX_WIDTH) ? row2_mem[c] : 0;
    mid = (c < MAX_WIDTH) ? row1_mem[c] : 0;
    lc = (c + 1 >= w);
    lr = (r + 1 >= h);
    if (r >= 2 && c >= 2) begin
      gx = (top + 2 * mid + bot) - (win[0] + 2 * win[1] + win[2]);
      gy = (win[2] + 2 * win[5] + bot) - (win[0] + 2 * win[3] + top);
      mag = int_sqrt(gx * gx + gy * gy);
      if (mag > 255) mag = 255;
      e.mag = mag[7:0];
      e.gx = gx[10:0];
      e.gy = gy[10:0];
      e.last = lc && lr;
      edge_q.push_back(e);
    end
    if (c < MAX_WIDTH) begin
      row2_mem[c] = mid[7:0];
      row1_mem[c] = px;
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[7:0];
    win[4] = mid[7:0];
    win[5] = px;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : ((r + 1) & 16'hffff);
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_res_t exp_r, got;
    if (!rst_ni) begin
      width_reg <= 11'd640;
      height_reg <= 16'd480;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr[2] == RegWidth) width_reg <= cfg_wdata[10:0];
        else height_reg <= cfg_wdata[15:0];
      end
      if (pix_valid && pix_ready) predict_pixel(pix_data, pix_first);
      if (res_valid && res_ready) begin
        result_count <= result_count + 1;
        got = {res_data[7:0], res_data[18:8], res_data[29:19], res_last};
        if (edge_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat %h", got);
        end else begin
          exp_r = edge_q.pop_front();
          if (got !== exp_r || res_data[31:30] !== 2'b00) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp mag %0d gx %0d gy %0d last %b, got mag %0d gx %0d gy %0d last %b",
                       exp_r.mag, $signed(exp_r.gx), $signed(exp_r.gy), exp_r.last,
                       got.mag, $signed(got.gx), $signed(got.gy), got.last);
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb.sv]
// testbench top: drives pixels, register writes and backpressure, reports the verdict
`timescale 1ns / 1ps
module tb;
  import sem_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // pixel
  logic        s_axis_tuser = 1'b0; // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // magnitude, grad_x, grad_y, zero fill
  logic        m_axis_tlast;        // frame_end
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending_count, result_count;
  int          beats_sent;
  bit          calm;
  int unsigned cur_w, cur_h;

  always #5 clk_i = ~clk_i;

  sobel_edge_magnitude_3x3 dut (.*);

  sem_checker chk (
    .clk_i, .rst_ni,
    .pix_valid(s_axis_tvalid), .pix_ready(s_axis_tready),
    .pix_data(s_axis_tdata), .pix_first(s_axis_tuser),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_data(m_axis_tdata), .res_last(m_axis_tlast),
    .cfg_we(psel && penable && pwrite && pready),
    .cfg_addr(paddr), .cfg_wdata(pwdata),
    .fail_count, .pending_count, .result_count
  );

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 17);
      if (!calm && $urandom_range(0, 2) == 0) begin
        repeat (n) @(posedge clk_i) m_axis_tready <= 1'b0;
      end else begin
        repeat (n) @(posedge clk_i) m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i) penable <= 1'b1;
    @(posedge clk_i) begin
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_drained();
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    cur_w = (w < 3) ? 3 : (w > 1024 ? 1024 : w);
    cur_h = (h < 3) ? 3 : h;
  endtask

  // tvalid stays high after an accepted beat until the next call or a drain
  task automatic send_pixel(input logic [7:0] px, input logic first);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  // mode 0 random, 1 all zero, 2 all max, 3 checker of extremes, 4 step edge
  task automatic send_frame(input int mode);
    for (int r = 0; r < cur_h; r++)
      for (int c = 0; c < cur_w; c++) begin
        logic [7:0] p;
        case (mode)
          0: p = $urandom_range(0, 255);
          1: p = 8'h00;
          2: p = 8'hff;
          3: p = ((r + c) % 2) ? 8'hff : 8'h00;
          default: p = (c >= cur_w / 2) ? 8'hff : 8'h00;
        endcase
        send_pixel(p, r == 0 && c == 0);
      end
  endtask

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    beats_sent = 0;
    calm = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, edges, clamped sizes
    set_frame(3, 3);
    for (int m = 1; m <= 4; m++) send_frame(m);
    set_frame(4, 4);
    send_frame(3);
    set_frame(1, 0);   // clamps to 3x3
    send_frame(4);
    send_frame(0);
    // frame wrap without frame_start, plus a few stray frame_start beats
    set_frame(5, 3);
    for (int i = 0; i < 30; i++) send_pixel($urandom_range(0, 255), i == 0);
    send_pixel(8'h80, 1'b1);
    for (int i = 0; i < 14; i++) send_pixel($urandom_range(0, 255), $urandom_range(0, 40) == 0);
    // random frames of varied size, each after a full drain
    while (beats_sent < 1080) begin
      set_frame($urandom_range(3, 24), $urandom_range(3, 8));
      send_frame($urandom_range(0, 9) < 8 ? 0 : $urandom_range(1, 4));
      if (beats_sent > 900) calm = 1;
    end
    wait_drained();
    $display("fed %0d pixels over frames from 3x3 to 24 wide, checked %0d result beats",
             beats_sent, result_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[filelist.f]
design/sem_pkg.sv
design/sem_isqrt.sv
design/sobel_edge_magnitude_3x3.sv
tb/sv/sem_checker.sv
tb/sv/tb.sv
